/* hw/rtl/ils_pkg.sv */
package ils_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             wr;
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

/* hw/rtl/ils_cell.sv */
module ils_cell #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IDX        = 0
) (
	input  logic                  clk,
	input  ils_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic [DATA_WIDTH-1:0] from_left,
	input  logic [DATA_WIDTH-1:0] from_right,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd
);
	import ils_pkg::*;

	localparam int unsigned IW = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;

	logic [DATA_WIDTH-1:0] data_q;
	logic [IW-1:0]         pos_w;
	logic [IW-1:0]         idx_w;
	logic                  hit;
	logic                  above;

	assign pos_w = IW'(ctl.pos);
	assign idx_w = IW'(IDX);
	assign hit   = (pos_w == idx_w);
	assign above = (idx_w > pos_w);

	always_ff @(posedge clk) begin
		if (ctl.wr && hit) begin
			data_q <= wdata;
		end else if (ctl.ins && above) begin
			data_q <= from_left;
		end else if (ctl.rem && (hit || above)) begin
			data_q <= from_right;
		end
	end

	assign data = data_q;
	assign rd   = hit ? data_q : '0;

endmodule

/* hw/rtl/indexed_list_store.sv */
// channel   signals                              transfer when
// command   start busy command position value   start & !busy
// result    done read_value status count         done
//
// one command per cycle; the result strobes on done the cycle after the transfer
// every cell shifts, loads or holds in parallel, so insert and remove move the whole row at once
// busy is held low: no command ever waits
// reset clears the length and the strobe; cell contents stay undefined until written
// the receiver cannot stall, each result shows for exactly one cycle
module indexed_list_store #(
	parameter int unsigned CAPACITY   = ils_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ils_pkg::CMD_W-1:0]    command,
	input  logic [ils_pkg::POS_W-1:0]    position,
	input  logic [ils_pkg::VAL_W-1:0]    value,
	output logic                         done,
	output logic [ils_pkg::VAL_W-1:0]    read_value,
	output logic [ils_pkg::STAT_W-1:0]   status,
	output logic [ils_pkg::COUNT_W-1:0]  count
);
	import ils_pkg::*;

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]         used_q;
	logic [CW-1:0]         used_d;
	logic                  done_q;
	logic [VAL_W-1:0]      read_value_q;
	status_t               status_q;
	status_t               st;
	logic                  get_ok;
	logic                  accept;
	cell_ctl_t             ctl;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       used_x;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_or;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_x  = CMPW'(position);
	assign used_x = CMPW'(used_q);
	assign wdata  = DATA_WIDTH'(value);

	always_comb begin
		st      = ST_OK;
		get_ok  = 1'b0;
		ctl.wr  = 1'b0;
		ctl.ins = 1'b0;
		ctl.rem = 1'b0;
		ctl.pos = position;
		used_d  = used_q;
		case (cmd_t'(command))
			CMD_GET: begin
				if (used_q == '0) begin
					st = ST_EMPTY;
				end else if (pos_x < used_x) begin
					get_ok = 1'b1;
				end else begin
					st = ST_INVALID;
				end
			end
			CMD_SET: begin
				if (pos_x < used_x) begin
					ctl.wr = accept;
				end else begin
					st = ST_INVALID;
				end
			end
			CMD_INSERT: begin
				if (pos_x > used_x) begin
					st = ST_INVALID;
				end else if (used_q == CW'(CAPACITY)) begin
					st = ST_FULL;
				end else begin
					ctl.wr  = accept;
					ctl.ins = accept;
					used_d  = used_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (pos_x < used_x) begin
					ctl.rem = accept;
					used_d  = used_q - CW'(1);
				end else begin
					st = ST_INVALID;
				end
			end
			CMD_CLEAR: begin
				used_d = '0;
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_inner_l
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_inner_r
			assign right = cell_data[i+1];
		end
		ils_cell #(
			.CAPACITY   (CAPACITY),
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wdata      (wdata),
			.from_left  (left),
			.from_right (right),
			.data       (cell_data[i]),
			.rd         (cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				used_q <= used_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= get_ok ? VAL_W'(rd_or) : '0;
			status_q     <= st;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = used_x[COUNT_W-1:0];

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import ils_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    command = '0;
	logic [POS_W-1:0]    position = '0;
	logic [VAL_W-1:0]    value = '0;
	logic                done;
	logic [VAL_W-1:0]    read_value;
	logic [STAT_W-1:0]   status;
	logic [COUNT_W-1:0]  count;

	logic [VAL_W-1:0]    list_data [CAPACITY];
	logic [COUNT_W-1:0]  list_len = '0;
	list_result_t        pending_results [$];
	int                  mismatch_count = 0;
	int                  idle_percent = 0;

	indexed_list_store DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.position   (position),
		.value      (value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.count      (count)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_result_t res;
		int i;
		res.read_value = '0;
		res.status = ST_OK;
		case (cmd)
		CMD_GET: begin
			if (list_len == 0)
				res.status = ST_EMPTY;
			else if (pos < list_len)
				res.read_value = list_data[IDX_W'(pos)];
			else
				res.status = ST_INVALID;
		end
		CMD_SET: begin
			if (pos < list_len)
				list_data[IDX_W'(pos)] = val;
			else
				res.status = ST_INVALID;
		end
		CMD_INSERT: begin
			if (pos > list_len)
				res.status = ST_INVALID;
			else if (list_len >= CAPACITY)
				res.status = ST_FULL;
			else begin
				for (i = int'(list_len); i > pos; i--)
					list_data[IDX_W'(i)] = list_data[IDX_W'(i-1)];
				list_data[IDX_W'(pos)] = val;
				list_len = list_len + 1'b1;
			end
		end
		CMD_REMOVE: begin
			if (pos < list_len) begin
				for (i = int'(pos); i + 1 < list_len; i++)
					list_data[IDX_W'(i)] = list_data[IDX_W'(i+1)];
				list_len = list_len - 1'b1;
			end else
				res.status = ST_INVALID;
		end
		CMD_CLEAR: begin
			list_len = '0;
		end
		default: begin
			res.status = ST_INVALID;
		end
		endcase
		res.count = list_len;
		return res;
	endfunction

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		start <= 1'b1;
		command <= cmd;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_list_command(cmd, pos, val));
		while (idle_percent != 0 && $urandom_range(99) < idle_percent) begin
			start <= 1'b0;
			command <= CMD_W'($urandom);
			position <= POS_W'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results;
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list;
		idle_percent = 0;
		send_command(CMD_GET, 5'd0, 32'h0);
		send_command(CMD_GET, 5'd31, 32'h0);
		send_command(CMD_SET, 5'd0, 32'hDEADBEEF);
		send_command(CMD_REMOVE, 5'd0, 32'h0);
		send_command(CMD_INSERT, 5'd1, 32'h11111111);
	endtask

	task automatic test_edit_entries;
		idle_percent = 0;
		send_command(CMD_INSERT, 5'd0, 32'h00000000);
		send_command(CMD_INSERT, 5'd1, 32'hFFFFFFFF);
		send_command(CMD_INSERT, 5'd0, 32'hA5A5A5A5);
		send_command(CMD_INSERT, 5'd3, 32'h12345678);
		send_command(CMD_INSERT, 5'd5, 32'h87654321);
		send_command(CMD_GET, 5'd0, 32'h0);
		send_command(CMD_GET, 5'd1, 32'h0);
		send_command(CMD_GET, 5'd3, 32'h0);
		send_command(CMD_GET, 5'd4, 32'h0);
		send_command(CMD_GET, 5'd31, 32'h0);
		send_command(CMD_SET, 5'd3, 32'h5A5A5A5A);
		send_command(CMD_SET, 5'd4, 32'hFFFFFFFF);
		send_command(CMD_REMOVE, 5'd1, 32'h0);
		send_command(CMD_REMOVE, 5'd2, 32'h0);
		send_command(CMD_REMOVE, 5'd16, 32'h0);
		send_command(3'd5, 5'd0, 32'hFFFFFFFF);
		send_command(3'd6, 5'd0, 32'h0);
		send_command(3'd7, 5'd31, 32'h0);
		send_command(CMD_GET, 5'd1, 32'h0);
		send_command(CMD_CLEAR, 5'd0, 32'h0);
		send_command(CMD_GET, 5'd0, 32'h0);
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct);
		int n;
		int mode;
		int pick;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		idle_percent = idle_pct;
		mode = 1;
		for (n = 0; n < items; n++) begin
			// mixed traffic, fill toward full, or drain toward empty
			if ($urandom_range(39) == 0)
				mode = $urandom_range(2);
			pick = $urandom_range(99);
			if (mode == 1)
				cmd = pick < 75 ? CMD_INSERT : pick < 90 ? CMD_GET : CMD_SET;
			else if (mode == 2)
				cmd = pick < 70 ? CMD_REMOVE : pick < 85 ? CMD_GET : CMD_SET;
			else if (pick < 25)
				cmd = CMD_GET;
			else if (pick < 45)
				cmd = CMD_SET;
			else if (pick < 65)
				cmd = CMD_INSERT;
			else if (pick < 85)
				cmd = CMD_REMOVE;
			else if (pick < 89)
				cmd = CMD_CLEAR;
			else if (pick < 92)
				cmd = CMD_W'($urandom_range(5, 7));
			else
				cmd = CMD_GET;
			if ($urandom_range(9) == 0)
				pos = POS_W'($urandom_range(31));
			else if (cmd == CMD_INSERT)
				pos = POS_W'($urandom_range(list_len));
			else if (list_len != 0)
				pos = POS_W'($urandom_range(list_len - 1'b1));
			else
				pos = '0;
			case ($urandom_range(9))
			0: val = '0;
			1: val = '1;
			default: val = $urandom;
			endcase
			send_command(cmd, pos, val);
		end
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: read_value %h status %0d count %0d",
					$time, read_value, status, count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, read_value);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatch_count++;
				end
				if (count !== want.count) begin
					$display("%0t: count expected %0d actual %0d", $time, want.count, count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#200000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_entries();
		wait_for_results();
		test_random_traffic(600, 27);
		wait_for_results();
		test_random_traffic(600, 73);
		wait_for_results();
		test_random_traffic(600, 0);
		wait_for_results();
		repeat (4)
			@(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
